// ===== rtl/wpbb_pkg.sv =====
// ----------------------------------------------------------------------------
// wpbb_pkg
// Shared types and constants of the watermark priority batch buffer.
// ----------------------------------------------------------------------------
package wpbb_pkg;

    // default buffer depth
    localparam int SLOT_COUNT_DEF = 16;

    // descriptor field widths
    localparam int PRIO_W   = 8;
    localparam int FRAME_W  = 16;
    localparam int STREAM_W = 10;
    localparam int TAG_W    = 32;
    localparam int THR_W    = 5;

    // stream word widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_FRAME     = 1'b1;

    // register reset values
    localparam logic [THR_W-1:0]   THR_RESET        = 5'd16;
    localparam logic [FRAME_W-1:0] LAST_FRAME_RESET = 16'd100;

    // one stored descriptor, priority in the lowest bits
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [STREAM_W-1:0] stream;
        logic [FRAME_W-1:0]  frame;
        logic [PRIO_W-1:0]   prio;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    // drain sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EVAL
    } t_back_state;

endpackage

// ===== rtl/wpbb_ram.sv =====
// ----------------------------------------------------------------------------
// wpbb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module wpbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/wpbb_fifo.sv =====
// ----------------------------------------------------------------------------
// wpbb_fifo
// Two-entry queue carrying flush commands from the front to the drain side.
// ----------------------------------------------------------------------------
module wpbb_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = r_count[1];
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rptr];

endmodule

// ===== rtl/wpbb_front.sv =====
// ----------------------------------------------------------------------------
// wpbb_front
// Accepts descriptors into the slot RAM and decides when a batch flushes.
// ----------------------------------------------------------------------------
module wpbb_front #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  wpbb_pkg::t_slot                   i_slot,
    input  logic [wpbb_pkg::THR_W-1:0]        i_fill_threshold,
    input  logic [wpbb_pkg::FRAME_W-1:0]      i_last_frame,
    output logic                              o_wr_en,
    output logic [$clog2(SLOT_COUNT)-1:0]     o_wr_addr,
    output wpbb_pkg::t_slot                   o_wr_data,
    input  logic                              i_q_full,
    output logic                              o_push,
    output logic [$clog2(SLOT_COUNT)+$clog2(SLOT_COUNT+1)+wpbb_pkg::PRIO_W-1:0] o_batch,
    input  logic                              i_rel_valid,
    input  logic [$clog2(SLOT_COUNT+1)-1:0]   i_rel_count
);

    import wpbb_pkg::*;

    localparam int ADDR_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W  = (CNT_W > THR_W) ? CNT_W : THR_W;

    logic [ADDR_W-1:0] r_wr_addr;
    logic [ADDR_W-1:0] r_base;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  r_free;
    logic [PRIO_W-1:0] r_maxp;

    logic              accept;
    logic [ADDR_W-1:0] n_wr_addr;
    logic [CNT_W-1:0]  fill_after;
    logic [PRIO_W-1:0] maxp_after;
    logic              flush;
    logic [CNT_W-1:0]  n_free;

    // room in the RAM and in the command queue
    assign o_ready = (r_free != '0) && !i_q_full;
    assign accept  = i_valid && o_ready;

    // insert and flush decision
    always_comb begin
        n_wr_addr  = (r_wr_addr == ADDR_W'(SLOT_COUNT - 1)) ? '0 : r_wr_addr + 1'b1;
        fill_after = r_fill + 1'b1;
        if (r_fill == '0 || i_slot.prio > r_maxp) begin
            maxp_after = i_slot.prio;
        end else begin
            maxp_after = r_maxp;
        end
        flush = (CMP_W'(fill_after) >= CMP_W'(i_fill_threshold))
             || (i_slot.frame == i_last_frame)
             || (fill_after == CNT_W'(SLOT_COUNT));
        n_free = r_free - CNT_W'(accept);
        if (i_rel_valid) begin
            n_free = n_free + i_rel_count;
        end
    end

    assign o_wr_en   = accept;
    assign o_wr_addr = r_wr_addr;
    assign o_wr_data = i_slot;
    assign o_push    = accept && flush;
    assign o_batch   = {maxp_after, fill_after, r_base};

    // fill tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_addr <= '0;
            r_base    <= '0;
            r_fill    <= '0;
            r_free    <= CNT_W'(SLOT_COUNT);
            r_maxp    <= '0;
        end else begin
            r_free <= n_free;
            if (accept) begin
                r_wr_addr <= n_wr_addr;
                r_maxp    <= maxp_after;
                if (flush) begin
                    r_fill <= '0;
                    r_base <= n_wr_addr;
                end else begin
                    r_fill <= fill_after;
                end
            end
        end
    end

endmodule

// ===== rtl/wpbb_back.sv =====
// ----------------------------------------------------------------------------
// wpbb_back
// Drains one batch in descending priority, one priority level per scan pass.
// ----------------------------------------------------------------------------
module wpbb_back #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  logic [$clog2(SLOT_COUNT)+$clog2(SLOT_COUNT+1)+wpbb_pkg::PRIO_W-1:0] i_batch,
    output logic                              o_pop,
    output logic                              o_rd_en,
    output logic [$clog2(SLOT_COUNT)-1:0]     o_rd_addr,
    input  wpbb_pkg::t_slot                   i_rd_data,
    input  logic [wpbb_pkg::FRAME_W-1:0]      i_last_frame,
    output logic                              o_rel_valid,
    output logic [$clog2(SLOT_COUNT+1)-1:0]   o_rel_count,
    output logic                              o_valid,
    input  logic                              i_ready,
    output wpbb_pkg::t_slot                   o_slot,
    output logic                              o_close,
    output logic                              o_last
);

    import wpbb_pkg::*;

    localparam int ADDR_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_idx;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_emit;
    logic [PRIO_W-1:0] r_cur;
    logic [PRIO_W-1:0] r_nxt;
    logic              r_nxt_v;
    logic              r_out_valid;
    t_slot             r_out_slot;
    logic              r_out_close;
    logic              r_out_last;

    logic              match;
    logic              stall;
    logic              step;
    logic              ld_out;
    logic              done;
    logic              last_scan;
    logic              cand;
    logic [CNT_W-1:0]  emit_after;
    logic [PRIO_W-1:0] nxt_after;
    logic [ADDR_W-1:0] addr_inc;

    // evaluation of the word last read from the RAM
    always_comb begin
        match      = i_rd_data.prio == r_cur;
        stall      = match && r_out_valid && !i_ready;
        emit_after = r_emit + CNT_W'(match);
        done       = emit_after == r_cnt;
        last_scan  = CNT_W'(r_idx) == r_cnt - 1'b1;
        cand       = (i_rd_data.prio < r_cur) && (!r_nxt_v || i_rd_data.prio > r_nxt);
        nxt_after  = cand ? i_rd_data.prio : r_nxt;
        addr_inc   = (r_addr == ADDR_W'(SLOT_COUNT - 1)) ? '0 : r_addr + 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                n_state = BK_EVAL;
            end
            BK_EVAL: begin
                if (!stall) begin
                    n_state = done ? BK_IDLE : BK_READ;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop   = 1'b0;
        o_rd_en = 1'b0;
        step    = 1'b0;
        unique case (r_state)
            BK_IDLE: o_pop   = i_q_valid;
            BK_READ: o_rd_en = 1'b1;
            BK_EVAL: step    = !stall;
            default: ;
        endcase
        ld_out = step && match;
    end

    assign o_rd_addr   = r_addr;
    assign o_rel_valid = step && done;
    assign o_rel_count = r_cnt;

    // scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (o_pop) begin
            r_base  <= i_batch[ADDR_W-1:0];
            r_addr  <= i_batch[ADDR_W-1:0];
            r_cnt   <= i_batch[ADDR_W +: CNT_W];
            r_cur   <= i_batch[ADDR_W+CNT_W +: PRIO_W];
            r_idx   <= '0;
            r_emit  <= '0;
            r_nxt_v <= 1'b0;
        end else if (step) begin
            r_emit <= emit_after;
            if (last_scan) begin
                r_cur   <= nxt_after;
                r_nxt_v <= 1'b0;
                r_idx   <= '0;
                r_addr  <= r_base;
            end else begin
                r_nxt   <= nxt_after;
                r_nxt_v <= r_nxt_v || cand;
                r_idx   <= r_idx + 1'b1;
                r_addr  <= addr_inc;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (ld_out) begin
            r_out_slot  <= i_rd_data;
            r_out_close <= i_rd_data.frame == i_last_frame;
            r_out_last  <= done;
        end
    end

    assign o_valid = r_out_valid;
    assign o_slot  = r_out_slot;
    assign o_close = r_out_close;
    assign o_last  = r_out_last;

endmodule

// ===== rtl/watermark_priority_batch_buffer.sv =====
// ----------------------------------------------------------------------------
// watermark_priority_batch_buffer
// Buffers frame descriptors and flushes them in bursts by priority.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one descriptor per word: priority, frame number, stream
//    id and payload tag. Each accepted word is stored in a slot RAM.
//  - a batch flushes when the fill count reaches fill_threshold, when the
//    frame number equals last_frame_number, or when the buffer is full.
//  - m_axis emits the batch largest priority first, arrival order kept among
//    equal priorities; tuser flags a closing stream, tlast ends the burst.
//  - the input keeps flowing while earlier batches drain, until the slots or
//    the two-entry flush queue run out.
//  - the drain scans the batch once per distinct priority, each slot with a
//    RAM read (BK_READ), then a compare (BK_EVAL); the drain time is bounded
//    by the single RAM read port. With the drain idle, the first result goes
//    from the flush queue through BK_IDLE, the slot reads and compares ahead
//    of it and its own, into the output register.
//  - reset clears the fill and drain control; slot contents are not cleared.
//  - when m_axis_tready is low the output register holds and the scan waits
//    once it reaches the next matching word; the input keeps taking words
//    until the free slots or the flush queue run out.
//  - the user writes configuration only while idle; the block does not check.
// ----------------------------------------------------------------------------
module watermark_priority_batch_buffer #(
    parameter int SLOT_COUNT = wpbb_pkg::SLOT_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // priority, frame_number, stream_id, frame_tag (lowest bit up)
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [wpbb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // out_priority, out_frame_number, out_stream_id, out_frame_tag (lowest up)
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [wpbb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    // close_stream
    output logic                                m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [wpbb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wpbb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import wpbb_pkg::*;

    localparam int ADDR_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int BATCH_W = ADDR_W + CNT_W + PRIO_W;

    logic [THR_W-1:0]   r_fill_threshold;
    logic [FRAME_W-1:0] r_last_frame;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    t_slot              wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [SLOT_W-1:0]  rd_data;
    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    logic [BATCH_W-1:0] q_in;
    logic [BATCH_W-1:0] q_out;
    logic               rel_valid;
    logic [CNT_W-1:0]   rel_count;
    t_slot              out_slot;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_threshold <= THR_RESET;
            r_last_frame     <= LAST_FRAME_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILL_THRESHOLD: r_fill_threshold <= i_cfg_data[THR_W-1:0];
                CFG_LAST_FRAME:     r_last_frame     <= i_cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    wpbb_front #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_slot          (t_slot'(s_axis_tdata[SLOT_W-1:0])),
        .i_fill_threshold(r_fill_threshold),
        .i_last_frame    (r_last_frame),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_batch         (q_in),
        .i_rel_valid     (rel_valid),
        .i_rel_count     (rel_count)
    );

    wpbb_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(SLOT_COUNT)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    wpbb_fifo #(
        .WIDTH(BATCH_W)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_out)
    );

    wpbb_back #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_batch     (q_out),
        .o_pop       (q_pop),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (t_slot'(rd_data)),
        .i_last_frame(r_last_frame),
        .o_rel_valid (rel_valid),
        .o_rel_count (rel_count),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_slot      (out_slot),
        .o_close     (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - SLOT_W)'(0), out_slot};

endmodule

// ===== rtl/wpbb_checker.sv =====
// ----------------------------------------------------------------------------
// wpbb_assertions
// Port-level checks of the batch buffer, bound to the top level.
// ----------------------------------------------------------------------------
module wpbb_assertions (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [wpbb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast,
    input logic                             m_axis_tuser
);

    import wpbb_pkg::*;

    logic              out_hs;
    logic              r_in_burst;
    logic [PRIO_W-1:0] r_prev_prio;

    assign out_hs = m_axis_tvalid && m_axis_tready;

    // track the priority of the last word taken inside a burst
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_burst <= 1'b0;
        end else if (out_hs) begin
            r_in_burst <= !m_axis_tlast;
        end
        if (out_hs) begin
            r_prev_prio <= m_axis_tdata[PRIO_W-1:0];
        end
    end

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // priorities never rise within a burst
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_hs && r_in_burst |-> m_axis_tdata[PRIO_W-1:0] <= r_prev_prio)
        else $error("priority rose within a burst");

    // nothing is shown right after reset
    a_reset_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    // an empty buffer takes input right after reset
    a_reset_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> s_axis_tready)
        else $error("input not ready right after reset");

endmodule

bind watermark_priority_batch_buffer wpbb_assertions u_assertions (.*);

// ===== dv/wpbb_checker.sv =====
// ----------------------------------------------------------------------------
// wpbb_checker
// Watches the stream and configuration ports of the batch buffer. It keeps
// its own copy of the slot buffer and registers, works out each flush burst
// in priority order and compares every output word with it.
// ----------------------------------------------------------------------------
module wpbb_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [wpbb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [wpbb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              m_axis_tlast,
    input  logic                              m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [wpbb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wpbb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_pending,
    output int                                o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import wpbb_pkg::*;

    localparam int DEPTH = SLOT_COUNT_DEF;

    // one expected output word
    typedef struct {
        t_slot desc;
        bit    close_stream;
        bit    burst_end;
    } t_burst_word;

    t_slot              slot_mem [DEPTH];
    int unsigned        wr_ptr;
    int unsigned        rd_ptr;
    int unsigned        fill_level;
    logic [THR_W-1:0]   threshold;
    logic [FRAME_W-1:0] last_frame;
    t_burst_word        burst_expected [$];
    int                 errors = 0;

    // store one descriptor, and on a flush queue the sorted burst
    task automatic store_and_flush(input t_slot d);
        int unsigned order [DEPTH];
        int unsigned n;
        int unsigned s;
        int unsigned k;
        bit          flush;
        t_burst_word bw;
        slot_mem[wr_ptr] = d;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (fill_level < DEPTH) fill_level++;
        flush = (fill_level >= threshold) || (d.frame == last_frame) ||
                (fill_level >= DEPTH);
        if (!flush) return;
        n = fill_level;
        // stable insertion sort, larger priority first
        for (int unsigned i = 0; i < n; i++) begin
            s = (rd_ptr + i) % DEPTH;
            k = i;
            while (k > 0 && slot_mem[order[k-1]].prio < slot_mem[s].prio) begin
                order[k] = order[k-1];
                k--;
            end
            order[k] = s;
        end
        for (int unsigned i = 0; i < n; i++) begin
            bw.desc         = slot_mem[order[i]];
            bw.close_stream = (bw.desc.frame == last_frame);
            bw.burst_end    = (i + 1 == n);
            burst_expected.push_back(bw);
        end
        rd_ptr     = wr_ptr;
        fill_level = 0;
    endtask

    // compare one output word with the oldest expected word
    task automatic check_out_word();
        t_burst_word exp_w;
        t_slot       got;
        got = t_slot'(m_axis_tdata[SLOT_W-1:0]);
        if (burst_expected.size() == 0) begin
            $error("output word with nothing expected: tdata=%h", m_axis_tdata);
            errors++;
            return;
        end
        exp_w = burst_expected.pop_front();
        if (got.prio !== exp_w.desc.prio) begin
            $error("out_priority: expected %0d, got %0d", exp_w.desc.prio, got.prio);
            errors++;
        end
        if (got.frame !== exp_w.desc.frame) begin
            $error("out_frame_number: expected %0d, got %0d", exp_w.desc.frame, got.frame);
            errors++;
        end
        if (got.stream !== exp_w.desc.stream) begin
            $error("out_stream_id: expected %0d, got %0d", exp_w.desc.stream, got.stream);
            errors++;
        end
        if (got.tag !== exp_w.desc.tag) begin
            $error("out_frame_tag: expected %h, got %h", exp_w.desc.tag, got.tag);
            errors++;
        end
        if (m_axis_tuser !== exp_w.close_stream) begin
            $error("close_stream: expected %0d, got %0d", exp_w.close_stream, m_axis_tuser);
            errors++;
        end
        if (m_axis_tlast !== exp_w.burst_end) begin
            $error("burst_end: expected %0d, got %0d", exp_w.burst_end, m_axis_tlast);
            errors++;
        end
    endtask

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_ptr     = 0;
            rd_ptr     = 0;
            fill_level = 0;
            threshold  = THR_RESET;
            last_frame = LAST_FRAME_RESET;
            burst_expected.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FILL_THRESHOLD: threshold = i_cfg_data[THR_W-1:0];
                    CFG_LAST_FRAME:     last_frame = i_cfg_data[FRAME_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                store_and_flush(t_slot'(s_axis_tdata[SLOT_W-1:0]));
            if (m_axis_tvalid && m_axis_tready)
                check_out_word();
        end
        o_pending    <= burst_expected.size();
        o_fail_count <= errors;
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the watermark priority batch buffer. A directed
// run covers field extremes, priority ties and the last-frame flush; random
// phases then sweep the threshold and last frame registers, with random
// gaps on both stream sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wpbb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 600;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    m_axis_tuser;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    int                      pending;
    int                      fail_count;
    int                      cycle_count = 0;
    logic [FRAME_W-1:0]      cur_last = LAST_FRAME_RESET;
    int                      send_calm = 0;
    int                      recv_calm = 0;
    int                      hold_req = 0;
    int                      hold_done = 0;

    watermark_priority_batch_buffer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    wpbb_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // idle cycles before a word, with calm stretches of no idling
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // random descriptor, biased toward priority ties and the last frame
    function automatic t_slot random_descriptor();
        t_slot d;
        case ($urandom_range(0, 3))
            0:       d.prio = PRIO_W'($urandom_range(0, 3));
            1:       d.prio = PRIO_W'(8'hFF - $urandom_range(0, 2));
            default: d.prio = PRIO_W'($urandom);
        endcase
        d.frame  = ($urandom_range(0, 11) == 0) ? cur_last : FRAME_W'($urandom);
        d.stream = STREAM_W'($urandom);
        d.tag    = $urandom;
        return d;
    endfunction

    // offer one word and wait until it is taken
    task automatic send_word(input t_slot d);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-SLOT_W){1'b0}}, d};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // descriptor carrying the current last frame number
    function automatic t_slot closing_descriptor();
        t_slot d;
        d       = random_descriptor();
        d.frame = cur_last;
        return d;
    endfunction

    // stop sending and wait until every burst word has come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // one register write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // output side: random stalls plus one long hold-off
    initial begin
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req != hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done++;
            end
            gap = draw_gap(recv_calm);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // stimulus and verdict
    initial begin
        logic [CFG_DATA_W-1:0] thr_set  [5] = '{16'd1, 16'hFFE0, 16'd31, 16'd4, 16'd16};
        logic [CFG_DATA_W-1:0] last_set [5] = '{16'd0, 16'hFFFF, 16'd12345, 16'd0, 16'd100};
        int                    cnt_set  [5] = '{12, 12, 35, 20, 20};
        t_slot                 d;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // field extremes and ties, flushed by the last frame at reset values
        send_word('{tag: 32'h0000_0000, stream: 10'd0,    frame: 16'd0,     prio: 8'd0});
        send_word('{tag: 32'hFFFF_FFFF, stream: 10'd1023, frame: 16'd65535, prio: 8'd255});
        send_word('{tag: 32'h0000_0001, stream: 10'd5,    frame: 16'd99,    prio: 8'd7});
        send_word('{tag: 32'h8000_0000, stream: 10'd512,  frame: 16'd1,     prio: 8'd255});
        send_word('{tag: 32'h1234_5678, stream: 10'd3,    frame: 16'd2,     prio: 8'd7});
        send_word('{tag: 32'h0000_FFFF, stream: 10'd1,    frame: 16'd101,   prio: 8'd0});
        send_word('{tag: 32'hDEAD_BEEF, stream: 10'd77,   frame: 16'd100,   prio: 8'd128});

        // a full buffer at the reset threshold
        for (int i = 0; i < 16; i++) begin
            d.prio   = PRIO_W'(((i * 37) % 5) * 60);
            d.frame  = FRAME_W'(200 + i);
            d.stream = STREAM_W'(i);
            d.tag    = $urandom;
            send_word(d);
        end
        settle();

        // random phases over several register settings
        last_set[3] = CFG_DATA_W'($urandom);
        for (int p = 0; p < 5; p++) begin
            cfg_write(CFG_FILL_THRESHOLD, thr_set[p]);
            cfg_write(CFG_LAST_FRAME, last_set[p]);
            cur_last = last_set[p];
            if (p == 2) hold_req++;
            for (int i = 0; i < cnt_set[p] - 1; i++)
                send_word(random_descriptor());
            // end each phase with an empty buffer
            send_word(closing_descriptor());
            settle();
        end

        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
